// File: src/complex_gaussian_lcg_generator_macros.svh
// assertion macros used by the sequencer module
`ifndef COMPLEX_GAUSSIAN_LCG_GENERATOR_MACROS_SVH
`define COMPLEX_GAUSSIAN_LCG_GENERATOR_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define CGLG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cglg assertion failed");

// next-cycle implication
`define CGLG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cglg assertion failed");

`endif

// File: src/cglg_pkg.sv
// shared types, constants and microcode program of the gaussian generator
package cglg_pkg;

   localparam int LcgWidth = 32;
   localparam int SumWidth = 34;
   localparam int OutWidth = 35;
   localparam int PcWidth  = 5;
   localparam int IdxWidth = 3;

   // register indexes of the csr port
   localparam logic [IdxWidth-1:0] REG_FAST_MODE   = 3'd0;
   localparam logic [IdxWidth-1:0] REG_MULT_MAIN   = 3'd1;
   localparam logic [IdxWidth-1:0] REG_INC_MAIN    = 3'd2;
   localparam logic [IdxWidth-1:0] REG_MULT_SECOND = 3'd3;
   localparam logic [IdxWidth-1:0] REG_INC_SECOND  = 3'd4;
   localparam logic [IdxWidth-1:0] REG_SEED_MAIN   = 3'd5;
   localparam logic [IdxWidth-1:0] REG_SEED_SECOND = 3'd6;
   localparam logic [IdxWidth-1:0] REG_SEED_GUARD  = 3'd7;

   // reset values
   localparam logic [LcgWidth-1:0] MULT_MAIN_RST   = 32'd1664525;
   localparam logic [LcgWidth-1:0] INC_MAIN_RST    = 32'd1013904223;
   localparam logic [LcgWidth-1:0] MULT_SECOND_RST = 32'd69069;
   localparam logic [LcgWidth-1:0] INC_SECOND_RST  = 32'd3;
   localparam logic [LcgWidth-1:0] GUARD_RST       = 32'd1;

   // 3.0 with 32 fraction bits
   localparam logic [OutWidth-1:0] THREE_FIX = 35'h3_0000_0000;

   // sequencer branch codes
   localparam logic [1:0] COND_NEXT     = 2'd0;  // go to pc + 1
   localparam logic [1:0] COND_ALWAYS   = 2'd1;  // go to target
   localparam logic [1:0] COND_DISPATCH = 2'd2;  // hold until transfer, then mode branch
   localparam logic [1:0] COND_OUTWAIT  = 2'd3;  // hold while result register full

   // program addresses
   localparam logic [PcWidth-1:0] PC_IDLE    = 5'd0;
   localparam logic [PcWidth-1:0] PC_FAST    = 5'd13;
   localparam logic [PcWidth-1:0] PC_FINISH  = 5'd20;
   localparam logic [PcWidth-1:0] PC_LAST    = 5'd20;

   typedef struct packed {
      logic                take;
      logic                clear;
      logic                step;
      logic                acc;
      logic                acc_t2;
      logic                load;
      logic [1:0]          cond;
      logic [PcWidth-1:0]  target;
   } cw_type;

   // control group handed from the sequencer to the datapath and top
   typedef struct packed {
      logic take;
      logic fire;
      logic clear;
      logic step;
      logic acc;
      logic acc_t2;
      logic load;
   } ctl_type;

   // seed load strobes
   typedef struct packed {
      logic main_we;
      logic second_we;
      logic guard_we;
   } seed_type;

   function automatic cw_type cw_make(logic take, logic clear, logic step, logic acc,
                                      logic acc_t2, logic load, logic [1:0] cond,
                                      logic [PcWidth-1:0] target);
      cw_type w;
      w.take   = take;
      w.clear  = clear;
      w.step   = step;
      w.acc    = acc;
      w.acc_t2 = acc_t2;
      w.load   = load;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   // control store: portable program at 1..12, fast program at 13..19
   function automatic cw_type rom_word(logic [PcWidth-1:0] pc);
      cw_type w;
      unique case (pc)
         5'd0:  w = cw_make(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, COND_DISPATCH, PC_FAST);
         5'd1:  w = cw_make(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, COND_NEXT, PC_IDLE);
         5'd2:  w = cw_make(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, COND_NEXT, PC_IDLE);
         5'd3:  w = cw_make(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, COND_NEXT, PC_IDLE);
         5'd4:  w = cw_make(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, COND_NEXT, PC_IDLE);
         5'd5:  w = cw_make(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, COND_NEXT, PC_IDLE);
         5'd6:  w = cw_make(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, COND_NEXT, PC_IDLE);
         5'd7:  w = cw_make(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, COND_NEXT, PC_IDLE);
         5'd8:  w = cw_make(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, COND_NEXT, PC_IDLE);
         5'd9:  w = cw_make(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, COND_NEXT, PC_IDLE);
         5'd10: w = cw_make(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, COND_NEXT, PC_IDLE);
         5'd11: w = cw_make(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, COND_NEXT, PC_IDLE);
         5'd12: w = cw_make(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, COND_ALWAYS, PC_FINISH);
         5'd13: w = cw_make(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, COND_NEXT, PC_IDLE);
         5'd14: w = cw_make(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, COND_NEXT, PC_IDLE);
         5'd15: w = cw_make(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, COND_NEXT, PC_IDLE);
         5'd16: w = cw_make(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, COND_NEXT, PC_IDLE);
         5'd17: w = cw_make(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, COND_NEXT, PC_IDLE);
         5'd18: w = cw_make(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, COND_NEXT, PC_IDLE);
         5'd19: w = cw_make(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, COND_NEXT, PC_IDLE);
         5'd20: w = cw_make(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, COND_OUTWAIT, PC_IDLE);
         default: w = cw_make(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, PC_IDLE);
      endcase
      return w;
   endfunction

endpackage

// File: src/cglg_seq.sv
// microcode sequencer: step counter, control store and branch logic
`include "complex_gaussian_lcg_generator_macros.svh"

module cglg_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              fast_mode,
   input  logic              out_busy,
   output cglg_pkg::ctl_type ctl
);
   import cglg_pkg::*;

   logic [PcWidth-1:0] pc_ff;
   logic [PcWidth-1:0] pc_in;
   cw_type             cw;
   logic               fire;

   // fetch the current control word
   assign cw   = rom_word(pc_ff);
   assign fire = cw.take & req_valid;

   // drive the control group
   always_comb begin
      ctl.take   = cw.take;
      ctl.fire   = fire;
      ctl.clear  = cw.clear & fire;
      ctl.step   = cw.step;
      ctl.acc    = cw.acc;
      ctl.acc_t2 = cw.acc_t2;
      ctl.load   = cw.load & ~out_busy;
   end

   // next step address
   always_comb begin
      unique case (cw.cond)
         COND_NEXT:     pc_in = pc_ff + 1'b1;
         COND_ALWAYS:   pc_in = cw.target;
         COND_DISPATCH: pc_in = !fire ? pc_ff : (fast_mode ? cw.target : pc_ff + 1'b1);
         COND_OUTWAIT:  pc_in = out_busy ? pc_ff : cw.target;
         default:       pc_in = PC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // the program counter stays inside the control store
   `CGLG_ASSERT_IMP(a_pc_range, clock, reset, 1'b1, pc_ff <= PC_LAST)
   // a transfer always leaves the idle step
   `CGLG_ASSERT_NXT(a_fire_leaves_idle, clock, reset, fire, pc_ff != PC_IDLE)
   // results are loaded only from the finishing step
   `CGLG_ASSERT_IMP(a_load_at_finish, clock, reset, ctl.load, pc_ff == PC_FINISH)
   // no accumulation while waiting for a request
   `CGLG_ASSERT_IMP(a_idle_quiet, clock, reset, pc_ff == PC_IDLE, !ctl.step && !ctl.acc)

endmodule

// File: src/cglg_dp.sv
// datapath: main and second lcg, guard, uniform forming and sum registers
module cglg_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  cglg_pkg::ctl_type                  ctl,
   input  cglg_pkg::seed_type                 seed_we,
   input  logic [cglg_pkg::LcgWidth-1:0]      seed_data,
   input  logic                               fast_mode,
   input  logic [cglg_pkg::LcgWidth-1:0]      mult_main,
   input  logic [cglg_pkg::LcgWidth-1:0]      inc_main,
   input  logic [cglg_pkg::LcgWidth-1:0]      mult_second,
   input  logic [cglg_pkg::LcgWidth-1:0]      inc_second,
   output logic [cglg_pkg::SumWidth-1:0]      t1,
   output logic [cglg_pkg::SumWidth-1:0]      t2
);
   import cglg_pkg::*;

   logic [LcgWidth-1:0] main_ff,   main_in;
   logic [LcgWidth-1:0] second_ff, second_in;
   logic [LcgWidth-1:0] guard_ff,  guard_in;
   logic [SumWidth-1:0] t1_ff,     t1_in;
   logic [SumWidth-1:0] t2_ff,     t2_in;

   logic [LcgWidth-1:0] main_step;
   logic [LcgWidth-1:0] second_step;
   logic [LcgWidth-1:0] diff;
   logic [LcgWidth-1:0] uniform;
   logic                bump;

   // lcg steps, low 32 bits of product plus increment
   assign main_step   = mult_main * main_ff + inc_main;
   assign second_step = mult_second * second_ff + inc_second;

   // uniform from the registered generator state
   assign diff    = main_ff - second_ff;
   assign uniform = fast_mode ? main_ff : {diff[LcgWidth-1:9], 1'b1, 8'h00};
   assign bump    = ctl.acc & ~fast_mode & (second_ff == guard_ff);

   // next state of generators
   always_comb begin
      main_in   = main_ff;
      second_in = second_ff;
      guard_in  = guard_ff;
      if (seed_we.main_we) begin
         main_in = seed_data;
      end else if (ctl.step) begin
         main_in = main_step;
      end
      if (seed_we.second_we) begin
         second_in = seed_data;
      end else if (ctl.step && !fast_mode) begin
         second_in = second_step;
      end else if (bump) begin
         second_in = second_ff + 1'b1;
      end
      if (seed_we.guard_we) begin
         guard_in = seed_data;
      end else if (bump) begin
         guard_in = guard_ff + 1'b1;
      end
   end

   // sum registers
   always_comb begin
      t1_in = t1_ff;
      t2_in = t2_ff;
      if (ctl.clear) begin
         t1_in = '0;
         t2_in = '0;
      end else if (ctl.acc) begin
         if (ctl.acc_t2) begin
            t2_in = t2_ff + SumWidth'(uniform);
         end else begin
            t1_in = t1_ff + SumWidth'(uniform);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_ff   <= '0;
         second_ff <= '0;
         guard_ff  <= GUARD_RST;
      end else begin
         main_ff   <= main_in;
         second_ff <= second_in;
         guard_ff  <= guard_in;
      end
   end

   always_ff @(posedge clock) begin
      t1_ff <= t1_in;
      t2_ff <= t2_in;
   end

   assign t1 = t1_ff;
   assign t2 = t2_ff;

endmodule

// File: src/complex_gaussian_lcg_generator.sv
// Requests are taken only at the idle step, so a new request waits until the previous result is loaded.
// One sample is produced per request; an output stall holds the sequencer at its finishing step.
// The sample rate is set by the microcode: one lcg multiply step per cycle in fast mode; in portable
// mode each multiply step is followed by a step for the difference, guard bump and accumulate.
// Reset (synchronous, active high): program at idle, registers at defaults, lcgs 0, guard 1.
// A finished result waits in the output register while the sequencer returns to idle.
module complex_gaussian_lcg_generator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_last_request,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [cglg_pkg::OutWidth-1:0] rsp_real_part,
   output logic signed [cglg_pkg::OutWidth-1:0] rsp_imag_part,
   output logic                                rsp_last_sample,
   input  logic                                csr_write_enable,
   input  logic [cglg_pkg::IdxWidth-1:0]       csr_index,
   input  logic [cglg_pkg::LcgWidth-1:0]       csr_write_data
);
   import cglg_pkg::*;

   logic                fast_mode_ff;
   logic [LcgWidth-1:0] mult_main_ff;
   logic [LcgWidth-1:0] inc_main_ff;
   logic [LcgWidth-1:0] mult_second_ff;
   logic [LcgWidth-1:0] inc_second_ff;
   seed_type            seed_we;
   ctl_type             ctl;
   logic [SumWidth-1:0] t1;
   logic [SumWidth-1:0] t2;
   logic                last_ff;
   logic                out_busy;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [OutWidth-1:0] real_ff;
   logic [OutWidth-1:0] imag_ff;
   logic                last_sample_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fast_mode_ff   <= 1'b0;
         mult_main_ff   <= MULT_MAIN_RST;
         inc_main_ff    <= INC_MAIN_RST;
         mult_second_ff <= MULT_SECOND_RST;
         inc_second_ff  <= INC_SECOND_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_FAST_MODE:   fast_mode_ff   <= csr_write_data[0];
            REG_MULT_MAIN:   mult_main_ff   <= csr_write_data;
            REG_INC_MAIN:    inc_main_ff    <= csr_write_data;
            REG_MULT_SECOND: mult_second_ff <= csr_write_data;
            REG_INC_SECOND:  inc_second_ff  <= csr_write_data;
            default:         ;
         endcase
      end
   end

   // seed writes load the generator state directly
   always_comb begin
      seed_we.main_we   = csr_write_enable & (csr_index == REG_SEED_MAIN);
      seed_we.second_we = csr_write_enable & (csr_index == REG_SEED_SECOND);
      seed_we.guard_we  = csr_write_enable & (csr_index == REG_SEED_GUARD);
   end

   assign out_busy  = rsp_valid_ff & rsp_stall;
   assign req_stall = ~ctl.take;

   cglg_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .fast_mode (fast_mode_ff),
      .out_busy  (out_busy),
      .ctl       (ctl)
   );

   cglg_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .seed_we     (seed_we),
      .seed_data   (csr_write_data),
      .fast_mode   (fast_mode_ff),
      .mult_main   (mult_main_ff),
      .inc_main    (inc_main_ff),
      .mult_second (mult_second_ff),
      .inc_second  (inc_second_ff),
      .t1          (t1),
      .t2          (t2)
   );

   // capture the pass-through flag on transfer
   always_ff @(posedge clock) begin
      if (ctl.fire) begin
         last_ff <= req_last_request;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         real_ff        <= THREE_FIX - OutWidth'(t1) - OutWidth'(t2);
         imag_ff        <= OutWidth'(t1) - OutWidth'(t2);
         last_sample_ff <= last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_real_part   = real_ff;
   assign rsp_imag_part   = imag_ff;
   assign rsp_last_sample = last_sample_ff;

endmodule
